// ===== sv/wrg_pkg.sv =====
// Shared constants, types and a helper function for the water ripple wave grid.
package wrg_pkg;

    localparam int GRID_SIZE = 64;
    localparam int CW        = $clog2(GRID_SIZE);
    localparam int AW        = 2 * CW;
    localparam int CELLS     = 1 << AW;
    localparam int HW        = 24;
    localparam int QW        = 17;
    localparam int FB        = 16;
    localparam int PW        = QW + CW;
    localparam int RW        = CW + 2;
    localparam int TW        = 20;
    localparam int SW        = 11;
    localparam int C2W       = 16;
    localparam int DW        = 17;
    localparam int NW        = 2 * PW + 2;
    localparam int ACC_W     = 64;
    localparam int MA_W      = 28;
    localparam int MB_W      = 17;

    localparam logic [QW-1:0] Q_ONE      = QW'(65536);
    localparam logic [TW-1:0] MIN_STEP   = TW'(1000);

    localparam logic [1:0] OP_IMPULSE = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_SAMPLE  = 2'd2;

    localparam logic [1:0] REG_WAVE_COEF = 2'd0;
    localparam logic [1:0] REG_DAMPING   = 2'd1;
    localparam logic [1:0] REG_SUBSTEP   = 2'd2;
    localparam logic [1:0] REG_ACC_CAP   = 2'd3;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_16 = 2'd1;
    localparam logic [1:0] SH_24 = 2'd2;

    typedef struct packed {
        logic       en;
        logic       clr;
        logic [1:0] sh;
    } mac_op_t;

    function automatic logic signed [HW-1:0] sat_h(input logic signed [ACC_W-1:0] v);
        logic signed [HW-1:0] r;
        if (v > ACC_W'(64'sd8388607)) begin
            r = HW'(24'sh7FFFFF);
        end else if (v < -ACC_W'(64'sd8388608)) begin
            r = HW'(24'sh800000);
        end else begin
            r = v[HW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/wrg_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module wrg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/wrg_mac.sv =====
// Shared signed multiply-accumulate unit with a selectable shift of the product.
module wrg_mac
    import wrg_pkg::*;
(
    input  logic                     clk,
    input  mac_op_t                  op,
    input  logic signed [MA_W-1:0]   a,
    input  logic [MB_W-1:0]          b,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [MA_W+MB_W:0]     prod;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       prod_sh;

    always_comb
    begin
        prod     = a * $signed({1'b0, b});
        prod_ext = ACC_W'(prod);
        case (op.sh)
            SH_16:   prod_sh = prod_ext <<< 16;
            SH_24:   prod_sh = prod_ext <<< 24;
            default: prod_sh = prod_ext;
        endcase
        acc_next = (op.clr ? ACC_W'(0) : acc_reg) + prod_sh;
    end

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== sv/water_ripple_wave_grid.sv =====
// Top level of the water ripple wave grid: sequencer, grid memories and ports.
//
// Items arrive on the s_ channel: tuser carries the opcode, tdata the operands.
// Every item gives exactly one word on the m_ channel. Register writes come on
// the cfg_ channel, which is always ready and must only be used while idle.
// After reset both height grids are cleared, one cell of each per cycle; no
// item is accepted until that pass has finished. One item is worked on at a
// time. An impulse registers its centre and radius, then its bounding box; the
// MAC forms each box cell's squared distance, and a cell inside the circle gets
// a bit-serial division, then its pressed height. A sample blends the four cells
// around its point. A time advance works each substep of the 64 by 64 grid cell
// by cell, paced by the single read port of the current grid, which delivers the
// five stencil taps. Other opcodes go straight to the output. A finished result
// sits in the output register; the next item is taken while it waits, and that
// item's own result is held back until the receiver has taken the earlier word.
module water_ripple_wave_grid
    import wrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // pos_u, pos_v, bump_radius, bump_strength, elapsed_time
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // sampled_height, substeps_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_IMP_SET  = 4'd2;
    localparam logic [3:0] ST_IMP_CELL = 4'd3;
    localparam logic [3:0] ST_IMP_DIV  = 4'd4;
    localparam logic [3:0] ST_IMP_FIN  = 4'd5;
    localparam logic [3:0] ST_ADV      = 4'd6;
    localparam logic [3:0] ST_SUB      = 4'd7;
    localparam logic [3:0] ST_SAMP     = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    localparam logic [CW-1:0] LAST = CW'(GRID_SIZE - 1);

    logic [3:0]              state_reg, state_next;
    logic [3:0]              ph_reg, ph_next;
    logic [CW-1:0]           x_reg, x_next, y_reg, y_next;
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [1:0]              op_reg, op_next;
    logic [QW-1:0]           u_reg, u_next, v_reg, v_next, rad_reg, rad_next;
    logic signed [HW-1:0]    str_reg, str_next;
    logic [C2W-1:0]          c2_reg;
    logic [DW-1:0]           damp_reg;
    logic [TW-1:0]           sub_reg, cap_reg;
    logic                    cur_b_reg, cur_b_next;
    logic [TW-1:0]           tacc_reg, tacc_next;
    logic [SW-1:0]           steps_reg, steps_next;
    logic signed [HW-1:0]    samp_reg, samp_next;
    logic signed [HW-1:0]    c_reg, c_next, p_reg, p_next, h_reg, h_next;
    logic signed [HW-1:0]    ihi_reg, ihi_next;
    logic signed [MA_W-1:0]  lap_reg, lap_next;
    logic [PW-1:0]           cx_reg, cx_next, cy_reg, cy_next;
    logic [RW-1:0]           r_reg, r_next;
    logic [2*RW-1:0]         rr_reg, rr_next;
    logic [CW-1:0]           xb0_reg, xb0_next, xb1_reg, xb1_next;
    logic [CW-1:0]           yb0_reg, yb0_next, yb1_reg, yb1_next;
    logic [NW-1:0]           num_reg, num_next, dv_reg, dv_next;
    logic [QW-1:0]           q_reg, q_next;
    logic [4:0]              dcnt_reg, dcnt_next;
    logic signed [ACC_W-1:0] top_reg, top_next, bot_reg, bot_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic signed [HW-1:0]    m_height_reg, m_height_next;
    logic [SW-1:0]           m_steps_reg, m_steps_next;

    mac_op_t                 mac_op;
    logic signed [MA_W-1:0]  mac_a;
    logic [MB_W-1:0]         mac_b;
    logic signed [ACC_W-1:0] mac_acc;

    logic                    wr_en, wr_cur, clearing, tgt_b;
    logic [AW-1:0]           wr_addr, rd_cur_addr, rd_prv_addr;
    logic signed [HW-1:0]    wr_data;
    logic [HW-1:0]           rd_a, rd_b;
    logic signed [HW-1:0]    cur_rd, prv_rd;

    logic [QW-1:0]           ucl, vcl;
    logic [PW-1:0]           pos_x, pos_y;
    logic [CW-1:0]           sx0, sx1, sy0, sy1;
    logic [MB_W-1:0]         wx0, wx1, wy0, wy1;
    logic [CW-1:0]           xl, xr, yu, yd;
    logic signed [PW:0]      dx, dy;
    logic [PW-1:0]           adx, ady;
    logic [QW+CW:0]          rsum;
    logic [RW-1:0]           r_raw;
    logic [RW:0]             ci_x, ci_y, lo_x, hi_x, lo_y, hi_y;
    logic [NW-1:0]           s_val, lim;
    logic [QW-1:0]           d2, t_val, w_val;
    logic signed [ACC_W-1:0] rnd32, rnd16;
    logic [TW-1:0]           step;
    logic [TW:0]             tsum;
    logic                    imp_last;
    logic [CW-1:0]           imp_nx, imp_ny;
    logic                    in_acc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'b0, m_steps_reg, m_height_reg};

    // Grid memories: one holds the current heights, the other the previous.
    assign tgt_b = wr_cur ? cur_b_reg : !cur_b_reg;

    wrg_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_ram_a (
        .clk   (clk),
        .we    (clearing || (wr_en && !tgt_b)),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (cur_b_reg ? rd_prv_addr : rd_cur_addr),
        .rdata (rd_a)
    );

    wrg_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_ram_b (
        .clk   (clk),
        .we    (clearing || (wr_en && tgt_b)),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (cur_b_reg ? rd_cur_addr : rd_prv_addr),
        .rdata (rd_b)
    );

    assign cur_rd = cur_b_reg ? rd_b : rd_a;
    assign prv_rd = cur_b_reg ? rd_a : rd_b;

    wrg_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .a   (mac_a),
        .b   (mac_b),
        .acc (mac_acc)
    );

    always_comb
    begin
        ucl   = (u_reg > Q_ONE) ? Q_ONE : u_reg;
        vcl   = (v_reg > Q_ONE) ? Q_ONE : v_reg;
        pos_x = PW'(ucl) * PW'(GRID_SIZE - 1);
        pos_y = PW'(vcl) * PW'(GRID_SIZE - 1);
        sx0   = pos_x[FB+CW-1:FB];
        sy0   = pos_y[FB+CW-1:FB];
        sx1   = (sx0 == LAST) ? sx0 : sx0 + CW'(1);
        sy1   = (sy0 == LAST) ? sy0 : sy0 + CW'(1);
        wx1   = MB_W'(pos_x[FB-1:0]);
        wy1   = MB_W'(pos_y[FB-1:0]);
        wx0   = MB_W'(Q_ONE) - wx1;
        wy0   = MB_W'(Q_ONE) - wy1;

        xl = (x_reg == '0) ? x_reg : x_reg - CW'(1);
        xr = (x_reg == LAST) ? x_reg : x_reg + CW'(1);
        yu = (y_reg == '0) ? y_reg : y_reg - CW'(1);
        yd = (y_reg == LAST) ? y_reg : y_reg + CW'(1);

        dx  = $signed({2'b0, x_reg, 16'b0}) - $signed({1'b0, cx_reg});
        dy  = $signed({2'b0, y_reg, 16'b0}) - $signed({1'b0, cy_reg});
        adx = dx[PW] ? PW'(-dx) : PW'(dx);
        ady = dy[PW] ? PW'(-dy) : PW'(dy);

        rsum  = (QW+CW+1)'(rad_reg) * (QW+CW+1)'(GRID_SIZE - 1) + (QW+CW+1)'(16'hFFFF);
        r_raw = rsum[QW+CW:FB];

        ci_x = (RW+1)'(cx_reg[FB+CW-1:FB]);
        ci_y = (RW+1)'(cy_reg[FB+CW-1:FB]);
        lo_x = (ci_x >= (RW+1)'(r_reg)) ? ci_x - (RW+1)'(r_reg) : '0;
        lo_y = (ci_y >= (RW+1)'(r_reg)) ? ci_y - (RW+1)'(r_reg) : '0;
        hi_x = ci_x + (RW+1)'(r_reg);
        hi_y = ci_y + (RW+1)'(r_reg);
        if (hi_x > (RW+1)'(GRID_SIZE - 1)) hi_x = (RW+1)'(GRID_SIZE - 1);
        if (hi_y > (RW+1)'(GRID_SIZE - 1)) hi_y = (RW+1)'(GRID_SIZE - 1);

        s_val = mac_acc[NW-1:0];
        lim   = NW'(rr_reg) << 32;
        d2    = (q_reg > Q_ONE) ? Q_ONE : q_reg;
        t_val = Q_ONE - d2;
        rnd32 = (mac_acc + ACC_W'(64'sh80000000)) >>> 32;
        rnd16 = (mac_acc + ACC_W'(64'sh8000)) >>> 16;
        w_val = QW'(rnd16);

        step = (sub_reg < MIN_STEP) ? MIN_STEP : sub_reg;
        tsum = (TW+1)'(tacc_reg) + (TW+1)'(s_tdata[94:75]);

        imp_last = (x_reg == xb1_reg) && (y_reg == yb1_reg);
        imp_nx   = (x_reg == xb1_reg) ? xb0_reg : x_reg + CW'(1);
        imp_ny   = (x_reg == xb1_reg) ? y_reg + CW'(1) : y_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        ph_next       = ph_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        clr_cnt_next  = clr_cnt_reg;
        op_next       = op_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        rad_next      = rad_reg;
        str_next      = str_reg;
        cur_b_next    = cur_b_reg;
        tacc_next     = tacc_reg;
        steps_next    = steps_reg;
        samp_next     = samp_reg;
        c_next        = c_reg;
        p_next        = p_reg;
        h_next        = h_reg;
        ihi_next      = ihi_reg;
        lap_next      = lap_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        r_next        = r_reg;
        rr_next       = rr_reg;
        xb0_next      = xb0_reg;
        xb1_next      = xb1_reg;
        yb0_next      = yb0_reg;
        yb1_next      = yb1_reg;
        num_next      = num_reg;
        dv_next       = dv_reg;
        q_next        = q_reg;
        dcnt_next     = dcnt_reg;
        top_next      = top_reg;
        bot_next      = bot_reg;
        m_tvalid_next = m_tvalid_reg;
        m_height_next = m_height_reg;
        m_steps_next  = m_steps_reg;

        mac_op      = '{en: 1'b0, clr: 1'b0, sh: SH_0};
        mac_a       = '0;
        mac_b       = '0;
        rd_cur_addr = '0;
        rd_prv_addr = '0;
        wr_en       = 1'b0;
        wr_cur      = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        clearing    = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clearing     = 1'b1;
                wr_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next    = s_tuser;
                    u_next     = s_tdata[16:0];
                    v_next     = s_tdata[33:17];
                    rad_next   = s_tdata[50:34];
                    str_next   = s_tdata[74:51];
                    steps_next = '0;
                    samp_next  = '0;
                    ph_next    = '0;
                    case (s_tuser)
                        OP_IMPULSE: state_next = ST_IMP_SET;
                        OP_ADVANCE:
                        begin
                            tacc_next  = (tsum > (TW+1)'(cap_reg)) ? cap_reg : tsum[TW-1:0];
                            state_next = ST_ADV;
                        end
                        OP_SAMPLE:  state_next = ST_SAMP;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end

            ST_IMP_SET:
            begin
                if (ph_reg == 4'd0)
                begin
                    cx_next = pos_x;
                    cy_next = pos_y;
                    r_next  = (r_raw == '0) ? RW'(1) : r_raw;
                    ph_next = 4'd1;
                end
                else
                begin
                    rr_next    = (2*RW)'(r_reg) * (2*RW)'(r_reg);
                    xb0_next   = CW'(lo_x);
                    xb1_next   = CW'(hi_x);
                    yb0_next   = CW'(lo_y);
                    yb1_next   = CW'(hi_y);
                    x_next     = CW'(lo_x);
                    y_next     = CW'(lo_y);
                    ph_next    = '0;
                    state_next = ST_IMP_CELL;
                end
            end

            ST_IMP_CELL:
            begin
                ph_next = ph_reg + 4'd1;
                case (ph_reg)
                    4'd0:
                    begin
                        rd_cur_addr = {y_reg, x_reg};
                        mac_op      = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                        mac_a       = MA_W'(adx);
                        mac_b       = MB_W'(adx[FB-1:0]);
                    end
                    4'd1:
                    begin
                        h_next = cur_rd;
                        mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_16};
                        mac_a  = MA_W'(adx);
                        mac_b  = MB_W'(adx[PW-1:FB]);
                    end
                    4'd2:
                    begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_0};
                        mac_a  = MA_W'(ady);
                        mac_b  = MB_W'(ady[FB-1:0]);
                    end
                    4'd3:
                    begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_16};
                        mac_a  = MA_W'(ady);
                        mac_b  = MB_W'(ady[PW-1:FB]);
                    end
                    default:
                    begin
                        ph_next = '0;
                        if (s_val > lim)
                        begin
                            x_next = imp_nx;
                            y_next = imp_ny;
                            if (imp_last)
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        else
                        begin
                            num_next   = s_val + (NW'(rr_reg) << 15);
                            dv_next    = lim;
                            q_next     = '0;
                            dcnt_next  = '0;
                            state_next = ST_IMP_DIV;
                        end
                    end
                endcase
            end

            ST_IMP_DIV:
            begin
                if (num_reg >= dv_reg)
                begin
                    num_next = num_reg - dv_reg;
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[QW-2:0], 1'b0};
                end
                dv_next   = dv_reg >> 1;
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == 5'(QW - 1))
                begin
                    ph_next    = '0;
                    state_next = ST_IMP_FIN;
                end
            end

            ST_IMP_FIN:
            begin
                ph_next = ph_reg + 4'd1;
                case (ph_reg)
                    4'd0:
                    begin
                        mac_op = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                        mac_a  = MA_W'(t_val);
                        mac_b  = MB_W'(t_val);
                    end
                    4'd1:
                    begin
                        mac_op = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                        mac_a  = MA_W'(str_reg);
                        mac_b  = MB_W'(w_val);
                    end
                    default:
                    begin
                        wr_en   = 1'b1;
                        wr_cur  = 1'b1;
                        wr_addr = {y_reg, x_reg};
                        wr_data = sat_h(ACC_W'(h_reg) - rnd16);
                        ph_next = '0;
                        x_next  = imp_nx;
                        y_next  = imp_ny;
                        state_next = imp_last ? ST_DONE : ST_IMP_CELL;
                    end
                endcase
            end

            ST_ADV:
            begin
                if (tacc_reg >= step)
                begin
                    x_next     = '0;
                    y_next     = '0;
                    ph_next    = '0;
                    state_next = ST_SUB;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_SUB:
            begin
                ph_next = ph_reg + 4'd1;
                case (ph_reg)
                    4'd0:
                    begin
                        rd_cur_addr = {y_reg, x_reg};
                        rd_prv_addr = {y_reg, x_reg};
                    end
                    4'd1:
                    begin
                        rd_cur_addr = {y_reg, xl};
                        c_next      = cur_rd;
                        p_next      = prv_rd;
                    end
                    4'd2:
                    begin
                        rd_cur_addr = {y_reg, xr};
                        lap_next    = MA_W'(cur_rd) - (MA_W'(c_reg) <<< 2);
                    end
                    4'd3:
                    begin
                        rd_cur_addr = {yu, x_reg};
                        lap_next    = lap_reg + MA_W'(cur_rd);
                    end
                    4'd4:
                    begin
                        rd_cur_addr = {yd, x_reg};
                        lap_next    = lap_reg + MA_W'(cur_rd);
                    end
                    4'd5:
                    begin
                        lap_next = lap_reg + MA_W'(cur_rd);
                    end
                    4'd6:
                    begin
                        mac_op = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                        mac_a  = lap_reg;
                        mac_b  = MB_W'(c2_reg);
                    end
                    4'd7:
                    begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_0};
                        mac_a  = (MA_W'(c_reg) <<< 1) - MA_W'(p_reg);
                        mac_b  = MB_W'(Q_ONE);
                    end
                    4'd8:
                    begin
                        ihi_next = mac_acc[47:24];
                        mac_op   = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                        mac_a    = MA_W'(mac_acc[23:0]);
                        mac_b    = damp_reg;
                    end
                    4'd9:
                    begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_24};
                        mac_a  = MA_W'(ihi_reg);
                        mac_b  = damp_reg;
                    end
                    default:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = {y_reg, x_reg};
                        wr_data = sat_h(rnd32);
                        ph_next = '0;
                        x_next  = x_reg + CW'(1);
                        if (x_reg == LAST)
                        begin
                            y_next = y_reg + CW'(1);
                            if (y_reg == LAST)
                            begin
                                cur_b_next = !cur_b_reg;
                                tacc_next  = tacc_reg - step;
                                steps_next = steps_reg + SW'(1);
                                state_next = ST_ADV;
                            end
                        end
                    end
                endcase
            end

            ST_SAMP:
            begin
                ph_next = ph_reg + 4'd1;
                case (ph_reg)
                    4'd0:
                    begin
                        rd_cur_addr = {sy0, sx0};
                    end
                    4'd1:
                    begin
                        rd_cur_addr = {sy0, sx1};
                        mac_op      = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                        mac_a       = MA_W'(cur_rd);
                        mac_b       = wx0;
                    end
                    4'd2:
                    begin
                        rd_cur_addr = {sy1, sx0};
                        mac_op      = '{en: 1'b1, clr: 1'b0, sh: SH_0};
                        mac_a       = MA_W'(cur_rd);
                        mac_b       = wx1;
                    end
                    4'd3:
                    begin
                        rd_cur_addr = {sy1, sx1};
                        top_next    = mac_acc;
                        mac_op      = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                        mac_a       = MA_W'(cur_rd);
                        mac_b       = wx0;
                    end
                    4'd4:
                    begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_0};
                        mac_a  = MA_W'(cur_rd);
                        mac_b  = wx1;
                    end
                    4'd5:
                    begin
                        bot_next = mac_acc;
                        mac_op   = '{en: 1'b1, clr: 1'b1, sh: SH_0};
                        mac_a    = MA_W'(top_reg[23:0]);
                        mac_b    = wy0;
                    end
                    4'd6:
                    begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_24};
                        mac_a  = top_reg[51:24];
                        mac_b  = wy0;
                    end
                    4'd7:
                    begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_0};
                        mac_a  = MA_W'(bot_reg[23:0]);
                        mac_b  = wy1;
                    end
                    4'd8:
                    begin
                        mac_op = '{en: 1'b1, clr: 1'b0, sh: SH_24};
                        mac_a  = bot_reg[51:24];
                        mac_b  = wy1;
                    end
                    default:
                    begin
                        samp_next  = sat_h(rnd32);
                        ph_next    = '0;
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_height_next = samp_reg;
                    m_steps_next  = steps_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            ph_reg       <= '0;
            clr_cnt_reg  <= '0;
            cur_b_reg    <= 1'b0;
            tacc_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            c2_reg       <= C2W'(20972);
            damp_reg     <= DW'(64684);
            sub_reg      <= TW'(16667);
            cap_reg      <= TW'(250000);
        end
        else
        begin
            state_reg    <= state_next;
            ph_reg       <= ph_next;
            clr_cnt_reg  <= clr_cnt_next;
            cur_b_reg    <= cur_b_next;
            tacc_reg     <= tacc_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WAVE_COEF: c2_reg   <= cfg_data[C2W-1:0];
                    REG_DAMPING:   damp_reg <= cfg_data[DW-1:0];
                    REG_SUBSTEP:   sub_reg  <= cfg_data;
                    REG_ACC_CAP:   cap_reg  <= cfg_data;
                    default:       cap_reg  <= cap_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        op_reg       <= op_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        rad_reg      <= rad_next;
        str_reg      <= str_next;
        steps_reg    <= steps_next;
        samp_reg     <= samp_next;
        c_reg        <= c_next;
        p_reg        <= p_next;
        h_reg        <= h_next;
        ihi_reg      <= ihi_next;
        lap_reg      <= lap_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        r_reg        <= r_next;
        rr_reg       <= rr_next;
        xb0_reg      <= xb0_next;
        xb1_reg      <= xb1_next;
        yb0_reg      <= yb0_next;
        yb1_reg      <= yb1_next;
        num_reg      <= num_next;
        dv_reg       <= dv_next;
        q_reg        <= q_next;
        dcnt_reg     <= dcnt_next;
        top_reg      <= top_next;
        bot_reg      <= bot_next;
        m_height_reg <= m_height_next;
        m_steps_reg  <= m_steps_next;
    end

endmodule

// ===== sv/wrg_chk.sv =====
// Port-level checker for the water ripple wave grid, bound to the top level.
module wrg_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Output word dropped while stalled.");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("A second item was taken while one was in work.");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("A result appeared without an item in work.");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:35] == 5'b0)
        else $error("Output padding bits are not zero.");

endmodule

bind water_ripple_wave_grid wrg_chk u_wrg_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/water_ripple_wave_grid_tb.sv =====
// Self-checking testbench for the water ripple wave grid against a predictor.
module water_ripple_wave_grid_tb
    import wrg_pkg::*;
;

    localparam int N = 64;
    localparam longint CYCLE_LIMIT = 40000000;

    typedef struct packed {
        logic signed [23:0] height;
        logic [10:0]        steps;
    } ripple_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;

    longint     heights [2][N*N];
    bit         cur_sel;
    longint     time_acc;
    longint     wave_coef;
    longint     damping;
    longint     step_len;
    longint     acc_cap;

    ripple_result_t pending_results [$];
    int          mismatches = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    longint      cycles = 0;

    water_ripple_wave_grid dut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        ripple_result_t got;
        ripple_result_t want;
        if (m_tvalid && m_tready)
        begin
            got.height = m_tdata[23:0];
            got.steps = m_tdata[34:24];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected word: height %0d steps %0d", got.height, got.steps);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.height !== want.height || got.steps !== want.steps)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected height %0d steps %0d, got height %0d steps %0d",
                                 want.height, want.steps, got.height, got.steps);
                end
            end
        end
    end

    function automatic longint clip_height(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic longint grid_coord(longint q);
        if (q > 65536)
            q = 65536;
        return q * (N - 1);
    endfunction

    function automatic void press_bump(longint u, longint v, longint rad, longint strength);
        longint cx, cy, r, cxi, cyi, x0, x1, y0, y1, rr, den, dx, dy, s, d2, t, w, delta;
        cx = grid_coord(u);
        cy = grid_coord(v);
        r = (rad * (N - 1) + 65535) >> 16;
        if (r < 1)
            r = 1;
        cxi = cx >> 16;
        cyi = cy >> 16;
        x0 = (cxi - r < 0) ? 0 : cxi - r;
        x1 = (cxi + r > N - 1) ? N - 1 : cxi + r;
        y0 = (cyi - r < 0) ? 0 : cyi - r;
        y1 = (cyi + r > N - 1) ? N - 1 : cyi + r;
        rr = r * r;
        den = rr << 16;
        for (longint y = y0; y <= y1; y++)
        begin
            dy = y * 65536 - cy;
            for (longint x = x0; x <= x1; x++)
            begin
                dx = x * 65536 - cx;
                s = dx * dx + dy * dy;
                if (s > (rr << 32))
                    continue;
                d2 = (s + den / 2) / den;
                if (d2 > 65536)
                    d2 = 65536;
                t = 65536 - d2;
                w = (t * t + 32768) >> 16;
                delta = (strength * w + 32768) >>> 16;
                heights[cur_sel][y*N+x] = clip_height(heights[cur_sel][y*N+x] - delta);
            end
        end
    endfunction

    function automatic void run_substep();
        longint c, lap, inner;
        int yu, yd, xl, xr;
        for (int y = 0; y < N; y++)
        begin
            yu = (y > 0) ? y - 1 : 0;
            yd = (y < N - 1) ? y + 1 : N - 1;
            for (int x = 0; x < N; x++)
            begin
                xl = (x > 0) ? x - 1 : 0;
                xr = (x < N - 1) ? x + 1 : N - 1;
                c = heights[cur_sel][y*N+x];
                lap = heights[cur_sel][y*N+xl] + heights[cur_sel][y*N+xr]
                    + heights[cur_sel][yu*N+x] + heights[cur_sel][yd*N+x] - 4 * c;
                inner = (2 * c - heights[!cur_sel][y*N+x]) * 65536 + wave_coef * lap;
                heights[!cur_sel][y*N+x] =
                    clip_height((damping * inner + (64'sd1 <<< 31)) >>> 32);
            end
        end
        cur_sel = !cur_sel;
    endfunction

    function automatic longint sample_height(longint u, longint v);
        longint px, py, x0, y0, x1, y1, fx, fy, top, bot;
        px = grid_coord(u);
        py = grid_coord(v);
        x0 = px >> 16;
        y0 = py >> 16;
        fx = px & 16'hFFFF;
        fy = py & 16'hFFFF;
        x1 = (x0 + 1 > N - 1) ? N - 1 : x0 + 1;
        y1 = (y0 + 1 > N - 1) ? N - 1 : y0 + 1;
        top = heights[cur_sel][y0*N+x0] * (65536 - fx) + heights[cur_sel][y0*N+x1] * fx;
        bot = heights[cur_sel][y1*N+x0] * (65536 - fx) + heights[cur_sel][y1*N+x1] * fx;
        return clip_height((top * (65536 - fy) + bot * fy + (64'sd1 <<< 31)) >>> 32);
    endfunction

    function automatic ripple_result_t predict_item(logic [1:0] op, longint u, longint v,
                                                     longint rad, longint strength, longint dt);
        ripple_result_t res;
        longint step, acc, n;
        res = '0;
        if (op == OP_IMPULSE)
        begin
            press_bump(u, v, rad, strength);
        end
        else if (op == OP_ADVANCE)
        begin
            step = (step_len < 1000) ? 1000 : step_len;
            acc = time_acc + dt;
            if (acc > acc_cap)
                acc = acc_cap;
            n = 0;
            while (acc >= step)
            begin
                run_substep();
                acc -= step;
                n++;
            end
            time_acc = acc;
            res.steps = n[10:0];
        end
        else if (op == OP_SAMPLE)
        begin
            res.height = 24'(sample_height(u, v));
        end
        return res;
    endfunction

    task automatic send_word(logic [1:0] op, logic [16:0] u, logic [16:0] v, logic [16:0] rad,
                             logic [23:0] strength, logic [19:0] dt);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, dt, strength, rad, v, u};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_item(op, u, v, rad, longint'($signed(strength)), dt));
        if ($urandom_range(99) < send_gap)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WAVE_COEF: wave_coef = value[15:0];
            REG_DAMPING:   damping = value[16:0];
            REG_SUBSTEP:   step_len = value;
            REG_ACC_CAP:   acc_cap = value;
            default: ;
        endcase
    endtask

    task automatic test_directed();
        send_word(OP_IMPULSE, 17'd0, 17'd0, 17'd0, 24'h7FFFFF, 20'd0);
        send_word(OP_IMPULSE, 17'd65536, 17'd65536, 17'd3000, 24'h800000, 20'hFFFFF);
        send_word(OP_IMPULSE, 17'd65536, 17'd65536, 17'd3000, 24'h800000, 20'd0);
        send_word(OP_IMPULSE, 17'h1FFFF, 17'd32768, 17'd2000, 24'd300000, 20'd0);
        send_word(OP_SAMPLE, 17'd0, 17'd0, 17'd0, 24'd0, 20'd0);
        send_word(OP_SAMPLE, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 24'hFFFFFF, 20'd0);
        send_word(OP_SAMPLE, 17'd64000, 17'd62000, 17'd0, 24'd0, 20'd0);
        send_word(2'd3, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 24'hFFFFFF, 20'hFFFFF);
        send_word(OP_ADVANCE, 17'd0, 17'd0, 17'd0, 24'd0, 20'd20000);
        send_word(OP_ADVANCE, 17'd0, 17'd0, 17'd0, 24'd0, 20'd0);
        send_word(OP_SAMPLE, 17'd65000, 17'd64500, 17'd0, 24'd0, 20'd0);
    endtask

    task automatic test_config_extremes();
        write_reg(REG_WAVE_COEF, 20'd32768);
        write_reg(REG_DAMPING, 20'd65536);
        write_reg(REG_SUBSTEP, 20'd1000000);
        write_reg(REG_ACC_CAP, 20'hFFFFF);
        send_word(OP_ADVANCE, 17'd0, 17'd0, 17'd0, 24'd0, 20'hFFFFF);
        send_word(OP_SAMPLE, 17'd64000, 17'd65536, 17'd0, 24'd0, 20'd0);
        write_reg(REG_WAVE_COEF, 20'd0);
        write_reg(REG_DAMPING, 20'd0);
        write_reg(REG_SUBSTEP, 20'd5);
        write_reg(REG_ACC_CAP, 20'd0);
        send_word(OP_ADVANCE, 17'd0, 17'd0, 17'd0, 24'd0, 20'hFFFFF);
        write_reg(REG_ACC_CAP, 20'd2500);
        send_word(OP_IMPULSE, 17'd30000, 17'd30000, 17'h1FFFF, 24'd65536, 20'd0);
        send_word(OP_ADVANCE, 17'd0, 17'd0, 17'd0, 24'd0, 20'hFFFFF);
        send_word(OP_SAMPLE, 17'd30000, 17'd30000, 17'd0, 24'd0, 20'd0);
    endtask

    task automatic test_random(int count);
        logic [1:0]  op;
        logic [16:0] rad;
        logic [19:0] dt;
        write_reg(REG_WAVE_COEF, 20'($urandom_range(32768)));
        write_reg(REG_DAMPING, 20'($urandom_range(60000, 65536)));
        write_reg(REG_SUBSTEP, 20'($urandom_range(40000, 60000)));
        write_reg(REG_ACC_CAP, 20'($urandom_range(60000, 100000)));
        for (int i = 0; i < count; i++)
        begin
            op = 2'($urandom_range(99) < 20 ? OP_ADVANCE : $urandom_range(3));
            rad = ($urandom_range(19) == 0) ? 17'($urandom) : 17'($urandom_range(4000));
            dt = ($urandom_range(7) == 0) ? 20'($urandom) : 20'($urandom_range(15000));
            if (op == OP_ADVANCE)
                send_word(op, 17'($urandom), 17'($urandom), rad, 24'($urandom), dt);
            else
                send_word(op, 17'($urandom), 17'($urandom), rad, 24'($urandom), 20'($urandom));
        end
    endtask

    initial
    begin
        foreach (heights[i, j])
            heights[i][j] = 0;
        cur_sel = 1'b0;
        time_acc = 0;
        wave_coef = 20972;
        damping = 64684;
        step_len = 16667;
        acc_cap = 250000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        send_gap = 18;
        recv_stall = 85;
        test_directed();
        test_config_extremes();
        test_random(34);
        send_gap = 85;
        recv_stall = 18;
        test_random(34);
        send_gap = 0;
        recv_stall = 0;
        test_random(34);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
